### hdl/ct3_pkg.sv
// ----------------------------------------------------------------------------
// ct3_pkg
// Shared types, register indexes and the compare helper of the 3x3 census
// transform.
// ----------------------------------------------------------------------------
package ct3_pkg;

	// fixed field widths
	localparam int PIX_W = 8;
	localparam int ROW_W = 12;
	localparam int CFG_W = 12;
	localparam int IDX_W = 1;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// register reset values and lower bound of both sizes
	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;
	localparam int SIZE_MIN     = 3;

	// result kinds of one item, in delivery order
	localparam int          KIND_N      = 4;
	localparam logic [1:0]  KIND_INNER  = 2'd0;
	localparam logic [1:0]  KIND_RIGHT  = 2'd1;
	localparam logic [1:0]  KIND_BELOW  = 2'd2;
	localparam logic [1:0]  KIND_CORNER = 2'd3;

	// one window column, top to bottom
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} column_t;

	// census bits of one column against the centre: [2] top, [1] mid, [0] bottom
	function automatic logic [2:0] census_gt(input column_t col, input logic [PIX_W-1:0] ctr);
		census_gt = {ctr > col.top, ctr > col.mid, ctr > col.bot};
	endfunction

endpackage

### hdl/ct3_ram.sv
// ----------------------------------------------------------------------------
// ct3_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ct3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/ct3_cell.sv
// ----------------------------------------------------------------------------
// ct3_cell
// One column cell of the window: holds a column, passes it on to the next
// cell on every shift and compares its values against the centre.
// ----------------------------------------------------------------------------
module ct3_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     shift,
	input  ct3_pkg::column_t         col_in,
	input  logic [ct3_pkg::PIX_W-1:0] centre,
	output ct3_pkg::column_t         col_q,
	output logic [2:0]               gt
);

	// column register, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	// centre compare of the held column
	assign gt = ct3_pkg::census_gt(col_q, centre);

endmodule

### hdl/ct3_emit.sv
// ----------------------------------------------------------------------------
// ct3_emit
// Result register: takes the result set of one item and hands out its
// results one per cycle while out_ready is high, inner result first.
// ----------------------------------------------------------------------------
module ct3_emit #(
	parameter int COL_W = 11
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [ct3_pkg::KIND_N-1:0]    load_mask,
	input  logic [ct3_pkg::PIX_W-1:0]     load_sig,
	input  logic [ct3_pkg::ROW_W-1:0]     load_row,
	input  logic [COL_W-1:0]              load_col,
	output logic                          free,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ct3_pkg::PIX_W-1:0]     signature,
	output logic [ct3_pkg::ROW_W-1:0]     out_row,
	output logic [COL_W-1:0]              out_column,
	output logic                          last
);

	logic [ct3_pkg::KIND_N-1:0] mask_q;
	logic [ct3_pkg::PIX_W-1:0]  sig_q;
	logic [ct3_pkg::ROW_W-1:0]  row_q;
	logic [COL_W-1:0]           col_q;
	logic [1:0]                 kind;
	logic [ct3_pkg::KIND_N-1:0] kind_bit;
	logic [ct3_pkg::KIND_N-1:0] rest;
	logic                       fire;

	// lowest pending result kind goes first
	always_comb begin
		if (mask_q[ct3_pkg::KIND_INNER]) begin
			kind = ct3_pkg::KIND_INNER;
		end else if (mask_q[ct3_pkg::KIND_RIGHT]) begin
			kind = ct3_pkg::KIND_RIGHT;
		end else if (mask_q[ct3_pkg::KIND_BELOW]) begin
			kind = ct3_pkg::KIND_BELOW;
		end else begin
			kind = ct3_pkg::KIND_CORNER;
		end
	end

	assign kind_bit  = ct3_pkg::KIND_N'(1) << kind;
	assign rest      = mask_q & ~kind_bit;
	assign out_valid = |mask_q;
	assign fire      = out_valid && out_ready;
	assign last      = (rest == '0);
	assign free      = !out_valid || (fire && last);

	// payload of the selected result
	always_comb begin
		case (kind)
			ct3_pkg::KIND_INNER: begin
				signature  = sig_q;
				out_row    = row_q - ct3_pkg::ROW_W'(1);
				out_column = col_q - COL_W'(1);
			end
			ct3_pkg::KIND_RIGHT: begin
				signature  = '0;
				out_row    = row_q - ct3_pkg::ROW_W'(1);
				out_column = col_q;
			end
			ct3_pkg::KIND_BELOW: begin
				signature  = '0;
				out_row    = row_q;
				out_column = col_q - COL_W'(1);
			end
			default: begin
				signature  = '0;
				out_row    = row_q;
				out_column = col_q;
			end
		endcase
	end

	// pending result mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= load_mask;
		end else if (fire) begin
			mask_q <= rest;
		end
	end

	// result set payload
	always_ff @(posedge clk) begin
		if (load) begin
			sig_q <= load_sig;
			row_q <= load_row;
			col_q <= load_col;
		end
	end

endmodule

### hdl/census_transform_3x3.sv
// ----------------------------------------------------------------------------
// census_transform_3x3
// 3x3 census transform over a raster-order stream of 8-bit gray pixels, with
// two line stores and a window built from a chain of column cells.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_ready    | pixel
//  out     | out_valid / out_ready  | signature, out_row, out_column, last
//  cfg     | cfg_we (no wait)       | cfg_index, cfg_data
//
//  One pixel per cycle is taken while in_ready is high; its first result
//  leaves the result register after the pixel stage, the rest follow one per
//  cycle while out_ready is high. A pixel gives no result in the first row or
//  first column, one inside the frame, two at the end of a row and elsewhere
//  in the last row, four at the end of the frame; each extra result holds back
//  the input. Reset clears the window, the counts and the registers
//  (640 x 480); line stores are not cleared. out_ready low holds the result
//  register and the pixel stage, and in_ready falls once both are occupied.
//
module census_transform_3x3 #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ct3_pkg::PIX_W-1:0]           pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ct3_pkg::PIX_W-1:0]           signature,
	output logic [ct3_pkg::ROW_W-1:0]           out_row,
	output logic [$clog2(MAX_WIDTH)-1:0]        out_column,
	output logic                                last,
	input  logic                                cfg_we,
	input  logic [ct3_pkg::IDX_W-1:0]           cfg_index,
	input  logic [ct3_pkg::CFG_W-1:0]           cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WIDTH_RST = (ct3_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
	                                                               : ct3_pkg::WIDTH_RESET;
	localparam logic [COL_W-1:0] WIDTH_LAST_RST = COL_W'(WIDTH_RST - 1);
	localparam logic [ct3_pkg::ROW_W-1:0] HEIGHT_LAST_RST =
		ct3_pkg::ROW_W'(ct3_pkg::HEIGHT_RESET - 1);

	logic [COL_W-1:0]           width_last_q;
	logic [ct3_pkg::ROW_W-1:0]  height_last_q;
	logic [COL_W-1:0]           width_last_nxt;
	logic [ct3_pkg::ROW_W-1:0]  height_last_nxt;
	logic [COL_W-1:0]           col_q;
	logic [ct3_pkg::ROW_W-1:0]  row_q;
	logic                       last_col;
	logic                       last_row;
	logic                       in_acc;

	logic                       valid_s1;
	logic [ct3_pkg::PIX_W-1:0]  pixel_s1;
	logic [COL_W-1:0]           col_s1;
	logic [ct3_pkg::ROW_W-1:0]  row_s1;
	logic                       last_col_s1;
	logic                       last_row_s1;
	logic                       adv_s1;

	logic [ct3_pkg::PIX_W-1:0]  top_rd;
	logic [ct3_pkg::PIX_W-1:0]  mid_rd;
	ct3_pkg::column_t           cur_col;
	ct3_pkg::column_t           col_b;
	ct3_pkg::column_t           col_a;
	logic [2:0]                 gt_a;
	logic [2:0]                 gt_b;
	logic [2:0]                 gt_c;
	logic [ct3_pkg::PIX_W-1:0]  census;
	logic [ct3_pkg::PIX_W-1:0]  sig;
	logic                       r_ge1;
	logic                       c_ge1;
	logic                       inner;
	logic [ct3_pkg::KIND_N-1:0] mask;
	logic                       emit_free;

	// effective sizes of a register write, stored as last index
	always_comb begin
		if (cfg_data < ct3_pkg::CFG_W'(ct3_pkg::SIZE_MIN)) begin
			width_last_nxt = COL_W'(ct3_pkg::SIZE_MIN - 1);
		end else if (int'(cfg_data) > MAX_WIDTH) begin
			width_last_nxt = COL_W'(MAX_WIDTH - 1);
		end else begin
			width_last_nxt = COL_W'(cfg_data - ct3_pkg::CFG_W'(1));
		end
		if (cfg_data < ct3_pkg::CFG_W'(ct3_pkg::SIZE_MIN)) begin
			height_last_nxt = ct3_pkg::ROW_W'(ct3_pkg::SIZE_MIN - 1);
		end else begin
			height_last_nxt = ct3_pkg::ROW_W'(cfg_data - ct3_pkg::CFG_W'(1));
		end
	end

	assign last_col = (col_q >= width_last_q);
	assign last_row = (row_q >= height_last_q);
	assign in_ready = !valid_s1 || emit_free;
	assign in_acc   = in_valid && in_ready;
	assign adv_s1   = valid_s1 && emit_free;

	// size registers and raster position; a register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= WIDTH_LAST_RST;
			height_last_q <= HEIGHT_LAST_RST;
			col_q         <= '0;
			row_q         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ct3_pkg::REG_FRAME_WIDTH: begin
					width_last_q <= width_last_nxt;
				end
				ct3_pkg::REG_FRAME_HEIGHT: begin
					height_last_q <= height_last_nxt;
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ct3_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// pixel stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// pixel stage payload, waits for the line store read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1    <= pixel;
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	// line stores: upper holds row r-2, middle row r-1
	ct3_ram #(.WIDTH(ct3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (top_rd)
	);

	ct3_ram #(.WIDTH(ct3_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_middle (
		.clk   (clk),
		.we    (adv_s1),
		.waddr (col_s1),
		.wdata (pixel_s1),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	// window: current column feeds cell b (c-1), which feeds cell a (c-2)
	assign cur_col = '{top: top_rd, mid: mid_rd, bot: pixel_s1};

	ct3_cell u_cell_b (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (adv_s1),
		.col_in (cur_col),
		.centre (col_b.mid),
		.col_q  (col_b),
		.gt     (gt_b)
	);

	ct3_cell u_cell_a (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (adv_s1),
		.col_in (col_b),
		.centre (col_b.mid),
		.col_q  (col_a),
		.gt     (gt_a)
	);

	assign gt_c = ct3_pkg::census_gt(cur_col, col_b.mid);

	// signature in raster neighbour order, centre skipped
	assign census = {gt_a[2], gt_b[2], gt_c[2], gt_a[1], gt_c[1], gt_a[0], gt_b[0], gt_c[0]};

	// border and result set of the item
	assign r_ge1 = (row_s1 != '0);
	assign c_ge1 = (col_s1 != '0);
	assign inner = (row_s1 >= ct3_pkg::ROW_W'(2)) && (col_s1 >= COL_W'(2));
	assign sig   = inner ? census : '0;

	always_comb begin
		mask = '0;
		mask[ct3_pkg::KIND_INNER]  = r_ge1 && c_ge1;
		mask[ct3_pkg::KIND_RIGHT]  = r_ge1 && last_col_s1;
		mask[ct3_pkg::KIND_BELOW]  = last_row_s1 && c_ge1;
		mask[ct3_pkg::KIND_CORNER] = last_row_s1 && last_col_s1;
	end

	// result register
	ct3_emit #(.COL_W(COL_W)) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv_s1),
		.load_mask  (mask),
		.load_sig   (sig),
		.load_row   (row_s1),
		.load_col   (col_s1),
		.free       (emit_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.signature  (signature),
		.out_row    (out_row),
		.out_column (out_column),
		.last       (last)
	);

endmodule

### hdl/ct3_checker.sv
// ----------------------------------------------------------------------------
// ct3_checker
// Port-level checks of the census transform: output handshake and the order
// of the results of one item.
// ----------------------------------------------------------------------------
module ct3_checker #(
	parameter int MAX_WIDTH = 2048
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ct3_pkg::PIX_W-1:0]     signature,
	input logic [ct3_pkg::ROW_W-1:0]     out_row,
	input logic [$clog2(MAX_WIDTH)-1:0]  out_column,
	input logic                          last
);

	// a stalled result stays
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(signature) && $stable(out_row)
			&& $stable(out_column) && $stable(last))
		else $error("result changed while stalled");

	// more results of the same item follow at once
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside the results of one item");

	// results of one item step one column right in the same row, or one row down
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=>
			(out_row == $past(out_row) && out_column == $past(out_column) + 1)
			|| out_row == $past(out_row) + 1)
		else $error("results of one item out of order");

endmodule

bind census_transform_3x3 ct3_checker #(.MAX_WIDTH(MAX_WIDTH)) u_ct3_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.signature  (signature),
	.out_row    (out_row),
	.out_column (out_column),
	.last       (last)
);
